// File: hw/rtl/srb_xon_pkg.sv
package srb_xon_pkg;

    localparam int DataW = 8;
    localparam int CodeW = 5;
    localparam int KindW = 3;
    localparam int StatW = 3;
    localparam int CfgIdxW = 3;
    localparam int OutTdataW = 32;

    localparam logic [DataW-1:0] XOFF_BYTE = 8'h13;
    localparam logic [DataW-1:0] XON_BYTE = 8'h11;

    localparam logic [DataW-1:0] RST_FLOW_THRESHOLD = 8'd65;
    localparam logic [CodeW-1:0] RST_STOP_CODE = 5'd0;
    localparam logic [CodeW-1:0] RST_RESUME_CODE = 5'd1;
    localparam logic [CodeW-1:0] RST_STATUS_CODE = 5'd2;
    localparam logic [CodeW-1:0] RST_SUPER_CODE = 5'd3;
    localparam logic [DataW-1:0] RST_RASTER_START = 8'd4;
    localparam logic [DataW-1:0] RST_RASTER_END = 8'd5;

    typedef enum logic [KindW-1:0] {
        KIND_LINE_RX     = 3'd0,
        KIND_PROTO_READ  = 3'd1,
        KIND_RASTER_READ = 3'd2,
        KIND_TX_WRITE    = 3'd3,
        KIND_LINE_READY  = 3'd4
    } kind_t;

    typedef enum logic [StatW-1:0] {
        RSTAT_OK          = 3'd0,
        RSTAT_EMPTY       = 3'd1,
        RSTAT_RASTER_BUSY = 3'd2,
        RSTAT_NOT_RASTER  = 3'd3,
        RSTAT_RASTER_IN   = 3'd4,
        RSTAT_RASTER_OUT  = 3'd5,
        RSTAT_TX_FULL     = 3'd6
    } read_status_t;

    typedef enum logic [1:0] {
        STOP_NONE     = 2'd0,
        STOP_REQUEST  = 2'd1,
        STOP_INVALID  = 2'd2,
        STOP_OVERFLOW = 2'd3
    } stop_reason_t;

    typedef enum logic [1:0] {
        EV_NONE        = 2'd0,
        EV_RESUME      = 2'd1,
        EV_STATUS      = 2'd2,
        EV_SUPERSTATUS = 2'd3
    } host_event_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FLOW_THRESHOLD = 3'd0,
        CFG_STOP_CODE      = 3'd1,
        CFG_RESUME_CODE    = 3'd2,
        CFG_STATUS_CODE    = 3'd3,
        CFG_SUPER_CODE     = 3'd4,
        CFG_RASTER_START   = 3'd5,
        CFG_RASTER_END     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic finish;
    } srb_cmd_t;

    typedef struct packed {
        logic             data_available;
        logic [1:0]       host_event;
        logic [1:0]       stop_reason;
        logic [DataW-1:0] line_byte;
        logic             line_valid;
        logic [StatW-1:0] read_status;
        logic [DataW-1:0] read_data;
    } srb_result_t;

endpackage

// File: hw/rtl/srb_xon_ctrl.sv
module srb_xon_ctrl
    import srb_xon_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    output logic     m_axis_tvalid,
    input  logic     m_axis_tready,
    output srb_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WRAP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_EXEC)
        else $error("capture not followed by execute");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid && state_reg == S_IDLE)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!m_valid_reg || m_axis_tready))
        else $error("result register overwritten before transfer");

endmodule

// File: hw/rtl/srb_xon_datapath.sv
module srb_xon_datapath
    import srb_xon_pkg::*;
#(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  srb_cmd_t           cmd,
    input  logic [KindW-1:0]   in_kind,
    input  logic [DataW-1:0]   in_byte,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DataW-1:0]   cfg_data,
    output srb_result_t        result
);

    localparam int RxAw = $clog2(RX_DEPTH);
    localparam int TxAw = $clog2(TX_DEPTH);
    localparam logic [RxAw-1:0] RxLast = RxAw'(RX_DEPTH - 1);
    localparam logic [TxAw-1:0] TxLast = TxAw'(TX_DEPTH - 1);

    logic [DataW-1:0] flow_threshold_reg;
    logic [CodeW-1:0] stop_code_reg, resume_code_reg, status_code_reg, super_code_reg;
    logic [DataW-1:0] raster_start_reg, raster_end_reg;

    logic [DataW-1:0] rx_mem [RX_DEPTH];
    logic [DataW-1:0] tx_mem [TX_DEPTH];
    logic [DataW-1:0] rx_q_reg, tx_q_reg;

    logic [RxAw-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [RxAw-1:0] rx_free_reg, rx_free_next;
    logic [TxAw-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic xoff_reg, xoff_next, xon_reg, xon_next;
    logic raster_reg, raster_next;

    logic [KindW-1:0] kind_reg;
    logic [DataW-1:0] byte_reg;

    logic [StatW-1:0] rstat_reg, rstat_next;
    logic [1:0]       stop_reg, stop_next, ev_reg, ev_next;
    logic             lvalid_reg, lvalid_next;
    logic [DataW-1:0] lbyte_reg, lbyte_next;
    logic             pop_rx_reg, pop_rx_next, pop_tx_reg, pop_tx_next;

    logic             rx_we, tx_we;
    logic [RxAw-1:0]  rx_wp_inc, rx_rp_inc;
    logic [TxAw-1:0]  tx_wp_inc, tx_rp_inc;
    logic             at_threshold, rx_empty;
    srb_result_t      result_reg, result_next;

    assign rx_wp_inc = (rx_wp_reg == RxLast) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RxLast) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TxLast) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TxLast) ? '0 : tx_rp_reg + 1'b1;
    assign at_threshold = (DataW'(rx_free_reg) == flow_threshold_reg);
    assign rx_empty = (rx_rp_reg == rx_wp_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_threshold_reg <= RST_FLOW_THRESHOLD;
            stop_code_reg <= RST_STOP_CODE;
            resume_code_reg <= RST_RESUME_CODE;
            status_code_reg <= RST_STATUS_CODE;
            super_code_reg <= RST_SUPER_CODE;
            raster_start_reg <= RST_RASTER_START;
            raster_end_reg <= RST_RASTER_END;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLOW_THRESHOLD: flow_threshold_reg <= cfg_data;
                CFG_STOP_CODE:      stop_code_reg <= cfg_data[CodeW-1:0];
                CFG_RESUME_CODE:    resume_code_reg <= cfg_data[CodeW-1:0];
                CFG_STATUS_CODE:    status_code_reg <= cfg_data[CodeW-1:0];
                CFG_SUPER_CODE:     super_code_reg <= cfg_data[CodeW-1:0];
                CFG_RASTER_START:   raster_start_reg <= cfg_data;
                CFG_RASTER_END:     raster_end_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // execute step: pointer and flag updates, memory access
    always_comb
    begin
        rx_wp_next = rx_wp_reg;
        rx_rp_next = rx_rp_reg;
        rx_free_next = rx_free_reg;
        tx_wp_next = tx_wp_reg;
        tx_rp_next = tx_rp_reg;
        xoff_next = xoff_reg;
        xon_next = xon_reg;
        rstat_next = RSTAT_OK;
        stop_next = STOP_NONE;
        ev_next = EV_NONE;
        lvalid_next = 1'b0;
        lbyte_next = '0;
        pop_rx_next = 1'b0;
        pop_tx_next = 1'b0;
        rx_we = 1'b0;
        tx_we = 1'b0;
        case (kind_reg) inside
            KIND_LINE_RX:
            begin
                if (byte_reg[DataW-1:CodeW] == '0)
                begin
                    if (byte_reg[CodeW-1:0] == stop_code_reg)
                        stop_next = STOP_REQUEST;
                    else if (byte_reg[CodeW-1:0] == resume_code_reg)
                        ev_next = EV_RESUME;
                    else if (byte_reg[CodeW-1:0] == status_code_reg)
                        ev_next = EV_STATUS;
                    else if (byte_reg[CodeW-1:0] == super_code_reg)
                        ev_next = EV_SUPERSTATUS;
                    else
                        stop_next = STOP_INVALID;
                end
                else
                begin
                    if (at_threshold)
                        xoff_next = 1'b1;
                    if (rx_wp_inc == rx_rp_reg)
                    begin
                        stop_next = STOP_OVERFLOW;
                    end
                    else
                    begin
                        rx_we = 1'b1;
                        rx_wp_next = rx_wp_inc;
                        if (rx_free_reg != '0)
                            rx_free_next = rx_free_reg - 1'b1;
                    end
                end
            end
            KIND_PROTO_READ, KIND_RASTER_READ:
            begin
                if ((kind_reg == KIND_PROTO_READ) && raster_reg)
                    rstat_next = RSTAT_RASTER_BUSY;
                else if ((kind_reg == KIND_RASTER_READ) && !raster_reg)
                    rstat_next = RSTAT_NOT_RASTER;
                else if (rx_empty)
                    rstat_next = RSTAT_EMPTY;
                else
                begin
                    pop_rx_next = 1'b1;
                    rx_rp_next = rx_rp_inc;
                    if (at_threshold)
                        xon_next = 1'b1;
                    if (rx_free_reg != RxLast)
                        rx_free_next = rx_free_reg + 1'b1;
                end
            end
            KIND_TX_WRITE:
            begin
                if (tx_wp_inc == tx_rp_reg)
                begin
                    rstat_next = RSTAT_TX_FULL;
                end
                else
                begin
                    tx_we = 1'b1;
                    tx_wp_next = tx_wp_inc;
                end
            end
            KIND_LINE_READY:
            begin
                if (xoff_reg)
                begin
                    xoff_next = 1'b0;
                    lvalid_next = 1'b1;
                    lbyte_next = XOFF_BYTE;
                end
                else if (xon_reg)
                begin
                    xon_next = 1'b0;
                    lvalid_next = 1'b1;
                    lbyte_next = XON_BYTE;
                end
                else if (tx_rp_reg != tx_wp_reg)
                begin
                    lvalid_next = 1'b1;
                    pop_tx_next = 1'b1;
                    tx_rp_next = tx_rp_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    // finish step: result assembly and data-dependent raster handling
    always_comb
    begin
        raster_next = raster_reg;
        result_next.read_data = '0;
        result_next.read_status = rstat_reg;
        result_next.line_valid = lvalid_reg;
        result_next.line_byte = pop_tx_reg ? tx_q_reg : lbyte_reg;
        result_next.stop_reason = stop_reg;
        result_next.host_event = ev_reg;
        result_next.data_available = !rx_empty;
        if (pop_rx_reg)
        begin
            if ((kind_reg == KIND_PROTO_READ) && (rx_q_reg == raster_start_reg))
            begin
                raster_next = 1'b1;
                result_next.read_status = RSTAT_RASTER_IN;
            end
            else if ((kind_reg == KIND_RASTER_READ) && (rx_q_reg == raster_end_reg))
            begin
                raster_next = 1'b0;
                result_next.read_status = RSTAT_RASTER_OUT;
            end
            else
            begin
                result_next.read_data = rx_q_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rx_q_reg <= rx_mem[rx_rp_reg];
            if (rx_we)
                rx_mem[rx_wp_reg] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            tx_q_reg <= tx_mem[tx_rp_reg];
            if (tx_we)
                tx_mem[tx_wp_reg] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.execute)
        begin
            rstat_reg <= rstat_next;
            stop_reg <= stop_next;
            ev_reg <= ev_next;
            lvalid_reg <= lvalid_next;
            lbyte_reg <= lbyte_next;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= '0;
            rx_wp_reg <= '0;
            rx_rp_reg <= '0;
            rx_free_reg <= RxLast;
            tx_wp_reg <= '0;
            tx_rp_reg <= '0;
            xoff_reg <= 1'b0;
            xon_reg <= 1'b0;
            raster_reg <= 1'b0;
            pop_rx_reg <= 1'b0;
            pop_tx_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                kind_reg <= in_kind;
            end
            if (cmd.execute)
            begin
                rx_wp_reg <= rx_wp_next;
                rx_rp_reg <= rx_rp_next;
                rx_free_reg <= rx_free_next;
                tx_wp_reg <= tx_wp_next;
                tx_rp_reg <= tx_rp_next;
                xoff_reg <= xoff_next;
                xon_reg <= xon_next;
                pop_rx_reg <= pop_rx_next;
                pop_tx_reg <= pop_tx_next;
            end
            if (cmd.finish)
            begin
                raster_reg <= raster_next;
            end
        end
    end

    assign result = result_reg;

    a_empty_all_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_rp_reg == rx_wp_reg) |-> (rx_free_reg == RxLast))
        else $error("empty receive ring with slots missing");

    a_raster_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(raster_reg))
        else $error("raster mode changed outside finish step");

    a_one_rx_pointer_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !($changed(rx_wp_reg) && $changed(rx_rp_reg)))
        else $error("both receive pointers moved in one step");

endmodule

// File: hw/rtl/serial_ring_buffer_xon_xoff_core.sv
// Serial link buffer engine with XON/XOFF receive flow control.
// Input stream: s_axis_tuser carries the event kind (line byte received,
// protocol read, raster read, transmit write, line ready), s_axis_tdata the
// byte. Every input transfer yields exactly one result transfer on m_axis.
// Configuration: cfg_valid/cfg_ready write cfg_data into the register at
// cfg_index (0 flow threshold, 1..4 command codes, 5/6 raster markers);
// cfg_ready is always high, writes take effect on the next cycle.
// Steps from the input transfer to m_axis_tvalid: capture on the accepting
// edge, ring update with registered memory read, result assembly.
// One item is in flight at a time, through the three-step controller
// sequence; the next input is accepted the cycle after the result is loaded.
// A result waiting on m_axis does not block the next input transfer; a new
// result is only loaded once the waiting one has been taken, so a stalled
// receiver holds the block in its final step and backs up s_axis.
// Reset: rings empty, pointers zero, free count RX_DEPTH-1, XON/XOFF and
// raster flags clear, registers at their default values. Ring contents are
// not cleared; an entry may be read before it is written, but such data is never used.
module serial_ring_buffer_xon_xoff_core
    import srb_xon_pkg::*;
#(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DataW-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic [KindW-1:0]     s_axis_tuser,  // [2:0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] read_data, [10:8] read_status, [11] line_valid, [19:12] line_byte,
    // [21:20] stop_reason, [23:22] host_event, [24] data_available, rest zero
    output logic [OutTdataW-1:0] m_axis_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [DataW-1:0]     cfg_data
);

    srb_cmd_t    cmd;
    srb_result_t result;

    assign cfg_ready = 1'b1;
    assign m_axis_tdata = OutTdataW'(result);

    srb_xon_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    srb_xon_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

// File: verif/tb_serial_ring_buffer_xon_xoff_core.sv
module tb_serial_ring_buffer_xon_xoff_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srb_xon_pkg::*;

    localparam int RX_SLOTS = 256;
    localparam int TX_SLOTS = 128;
    localparam int RxPtrW = $clog2(RX_SLOTS);
    localparam int TxPtrW = $clog2(TX_SLOTS);
    localparam int ResW = $bits(srb_result_t);

    // kinds with no defined action, and a config index with no register behind it
    localparam logic [KindW-1:0] KIND_RSVD_LO = 3'd5;
    localparam logic [KindW-1:0] KIND_RSVD_HI = 3'd7;
    localparam logic [CfgIdxW-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [DataW-1:0] data;
    } link_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DataW-1:0]     s_axis_tdata = '0;
    logic [KindW-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutTdataW-1:0] m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [DataW-1:0]     cfg_data = '0;

    serial_ring_buffer_xon_xoff_core #(
        .RX_DEPTH (RX_SLOTS),
        .TX_DEPTH (TX_SLOTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow of the link buffer state and registers
    logic [DataW-1:0]  rx_shadow [0:RX_SLOTS-1];
    logic [DataW-1:0]  tx_shadow [0:TX_SLOTS-1];
    logic [RxPtrW-1:0] rx_wr = '0;
    logic [RxPtrW-1:0] rx_rd = '0;
    logic [RxPtrW-1:0] rx_free = RxPtrW'(RX_SLOTS - 1);
    logic [TxPtrW-1:0] tx_wr = '0;
    logic [TxPtrW-1:0] tx_rd = '0;
    logic              xoff_due = 1'b0;
    logic              xon_due = 1'b0;
    logic              raster_on = 1'b0;

    logic [DataW-1:0] thr_cfg = RST_FLOW_THRESHOLD;
    logic [CodeW-1:0] stop_cfg = RST_STOP_CODE;
    logic [CodeW-1:0] resume_cfg = RST_RESUME_CODE;
    logic [CodeW-1:0] status_cfg = RST_STATUS_CODE;
    logic [CodeW-1:0] super_cfg = RST_SUPER_CODE;
    logic [DataW-1:0] rstart_cfg = RST_RASTER_START;
    logic [DataW-1:0] rend_cfg = RST_RASTER_END;

    link_event_t pending_events [$];
    srb_result_t expected_results [$];
    link_event_t next_event;
    int          err_cnt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        on_bus = 1'b0;
    logic [9:0]  ready_tick;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [DataW-1:0] pop_rx_byte();
        logic [DataW-1:0] b;
        b = rx_shadow[rx_rd];
        rx_rd = rx_rd + 1'b1;
        if (rx_free == thr_cfg)
            xon_due = 1'b1;
        if (rx_free != RxPtrW'(RX_SLOTS - 1))
            rx_free = rx_free + 1'b1;
        return b;
    endfunction

    function automatic srb_result_t predict_link_step(input logic [KindW-1:0] kind,
                                                      input logic [DataW-1:0] b);
        srb_result_t       r;
        logic [DataW-1:0]  d;
        logic [RxPtrW-1:0] rx_nxt;
        logic [TxPtrW-1:0] tx_nxt;
        r = '0;
        rx_nxt = rx_wr + 1'b1;
        tx_nxt = tx_wr + 1'b1;
        case (kind)
            KIND_LINE_RX:
            begin
                if (b < 8'd32)
                begin
                    if (b[CodeW-1:0] == stop_cfg)
                        r.stop_reason = STOP_REQUEST;
                    else if (b[CodeW-1:0] == resume_cfg)
                        r.host_event = EV_RESUME;
                    else if (b[CodeW-1:0] == status_cfg)
                        r.host_event = EV_STATUS;
                    else if (b[CodeW-1:0] == super_cfg)
                        r.host_event = EV_SUPERSTATUS;
                    else
                        r.stop_reason = STOP_INVALID;
                end
                else
                begin
                    if (rx_free == thr_cfg)
                        xoff_due = 1'b1;
                    if (rx_nxt == rx_rd)
                        r.stop_reason = STOP_OVERFLOW;
                    else
                    begin
                        rx_shadow[rx_wr] = b;
                        rx_wr = rx_nxt;
                        if (rx_free != '0)
                            rx_free = rx_free - 1'b1;
                    end
                end
            end
            KIND_PROTO_READ:
            begin
                if (raster_on)
                    r.read_status = RSTAT_RASTER_BUSY;
                else if (rx_rd == rx_wr)
                    r.read_status = RSTAT_EMPTY;
                else
                begin
                    d = pop_rx_byte();
                    if (d == rstart_cfg)
                    begin
                        raster_on = 1'b1;
                        r.read_status = RSTAT_RASTER_IN;
                    end
                    else
                        r.read_data = d;
                end
            end
            KIND_RASTER_READ:
            begin
                if (!raster_on)
                    r.read_status = RSTAT_NOT_RASTER;
                else if (rx_rd == rx_wr)
                    r.read_status = RSTAT_EMPTY;
                else
                begin
                    d = pop_rx_byte();
                    if (d == rend_cfg)
                    begin
                        raster_on = 1'b0;
                        r.read_status = RSTAT_RASTER_OUT;
                    end
                    else
                        r.read_data = d;
                end
            end
            KIND_TX_WRITE:
            begin
                if (tx_nxt == tx_rd)
                    r.read_status = RSTAT_TX_FULL;
                else
                begin
                    tx_shadow[tx_wr] = b;
                    tx_wr = tx_nxt;
                end
            end
            KIND_LINE_READY:
            begin
                if (xoff_due)
                begin
                    xoff_due = 1'b0;
                    r.line_valid = 1'b1;
                    r.line_byte = XOFF_BYTE;
                end
                else if (xon_due)
                begin
                    xon_due = 1'b0;
                    r.line_valid = 1'b1;
                    r.line_byte = XON_BYTE;
                end
                else if (tx_rd != tx_wr)
                begin
                    r.line_valid = 1'b1;
                    r.line_byte = tx_shadow[tx_rd];
                    tx_rd = tx_rd + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.data_available = (rx_rd != rx_wr);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(input logic [OutTdataW-1:0] word);
        srb_result_t got;
        srb_result_t want;
        got = word[ResW-1:0];
        if (expected_results.size() == 0)
            report_mismatch("result with none outstanding", word, 0);
        else
        begin
            want = expected_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.read_status !== want.read_status)
                report_mismatch("read_status", got.read_status, want.read_status);
            if (got.line_valid !== want.line_valid)
                report_mismatch("line_valid", got.line_valid, want.line_valid);
            if (got.line_byte !== want.line_byte)
                report_mismatch("line_byte", got.line_byte, want.line_byte);
            if (got.stop_reason !== want.stop_reason)
                report_mismatch("stop_reason", got.stop_reason, want.stop_reason);
            if (got.host_event !== want.host_event)
                report_mismatch("host_event", got.host_event, want.host_event);
            if (got.data_available !== want.data_available)
                report_mismatch("data_available", got.data_available, want.data_available);
            if (word[OutTdataW-1:ResW] !== '0)
                report_mismatch("unused tdata bits", word, 0);
        end
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_link_step(s_axis_tuser, s_axis_tdata));
                on_bus = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_events.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    next_event = pending_events.pop_front();
                    on_bus = 1'b1;
                    s_axis_tuser <= next_event.kind;
                    s_axis_tdata <= next_event.data;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(24, 1);
                        if ($urandom_range(15, 0) == 0)
                            gap_left = 20;
                        else if ($urandom_range(2, 0) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(6, 1);
                    end
                end
            end
        end
    end

    // monitor: receiver cycles through ready, random, sparse and mostly-ready windows
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_tick <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            ready_tick <= ready_tick + 1'b1;
            case (ready_tick[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(1, 0) == 1);
                2'd2: m_axis_tready <= (ready_tick[2:0] == 3'd0);
                default: m_axis_tready <= ($urandom_range(4, 0) != 0);
            endcase
        end
    end

    task automatic push_event(input logic [KindW-1:0] kind, input logic [DataW-1:0] data);
        link_event_t e;
        e.kind = kind;
        e.data = data;
        pending_events.push_back(e);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FLOW_THRESHOLD: thr_cfg = val;
            CFG_STOP_CODE:      stop_cfg = val[CodeW-1:0];
            CFG_RESUME_CODE:    resume_cfg = val[CodeW-1:0];
            CFG_STATUS_CODE:    status_cfg = val[CodeW-1:0];
            CFG_SUPER_CODE:     super_cfg = val[CodeW-1:0];
            CFG_RASTER_START:   rstart_cfg = val;
            CFG_RASTER_END:     rend_cfg = val;
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_events.size() != 0 || on_bus || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // well-formed runs of fills, reads, transmit traffic, plus some noise
    task automatic add_random_mix(input int n);
        int               counted;
        int               k;
        int               len;
        logic [KindW-1:0] kd;
        logic [DataW-1:0] b;
        counted = 0;
        while (counted < n)
        begin
            len = $urandom_range(12, 1);
            case ($urandom_range(9, 0)) inside
                [0:3]:
                begin
                    for (k = 0; k < len; k++)
                    begin
                        case ($urandom_range(7, 0))
                            0: b = rstart_cfg;
                            1: b = rend_cfg;
                            2: b = 8'($urandom_range(31, 0));
                            default: b = 8'($urandom_range(255, 32));
                        endcase
                        push_event(KIND_LINE_RX, b);
                    end
                    counted += len;
                end
                [4:6]:
                begin
                    for (k = 0; k < len; k++)
                        push_event(($urandom_range(1, 0) == 1) ? KIND_PROTO_READ
                                                              : KIND_RASTER_READ,
                                   8'($urandom));
                    counted += len;
                end
                7:
                begin
                    for (k = 0; k < len / 2 + 1; k++)
                        push_event(KIND_TX_WRITE, 8'($urandom));
                    counted += len / 2 + 1;
                end
                8:
                begin
                    for (k = 0; k < len / 2 + 1; k++)
                        push_event(KIND_LINE_READY, 8'($urandom));
                    counted += len / 2 + 1;
                end
                default:
                begin
                    kd = 3'($urandom_range(7, 0));
                    push_event(kd, 8'($urandom));
                    if (kd <= KIND_LINE_READY)
                        counted++;
                end
            endcase
        end
    endtask

    initial
    begin
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        push_event(KIND_LINE_RX, {3'b000, RST_STOP_CODE});
        push_event(KIND_LINE_RX, {3'b000, RST_RESUME_CODE});
        push_event(KIND_LINE_RX, {3'b000, RST_STATUS_CODE});
        push_event(KIND_LINE_RX, {3'b000, RST_SUPER_CODE});
        push_event(KIND_LINE_RX, 8'd31);
        push_event(KIND_LINE_RX, RST_RASTER_START);
        push_event(KIND_LINE_RX, 8'h20);
        push_event(KIND_LINE_RX, 8'hFF);
        push_event(KIND_LINE_RX, 8'h80);
        for (k = 0; k < 4; k++)
            push_event(KIND_PROTO_READ, 8'h00);
        push_event(KIND_RASTER_READ, 8'hFF);
        push_event(KIND_TX_WRITE, 8'h00);
        push_event(KIND_TX_WRITE, 8'hFF);
        for (k = 0; k < 3; k++)
            push_event(KIND_LINE_READY, 8'h00);
        for (k = KIND_RSVD_LO; k <= KIND_RSVD_HI; k++)
            push_event(3'(k), 8'hFF);
        wait_idle();

        // high threshold, overlapping command codes, wide values, raster markers at extremes
        write_reg(CFG_FLOW_THRESHOLD, 8'd254);
        write_reg(CFG_STOP_CODE, 8'd31);
        write_reg(CFG_RESUME_CODE, 8'd31);
        write_reg(CFG_STATUS_CODE, 8'hE5);
        write_reg(CFG_SUPER_CODE, 8'd5);
        write_reg(CFG_RASTER_START, 8'hFF);
        write_reg(CFG_RASTER_END, 8'd32);
        write_reg(CFG_NO_REG, 8'hAA);
        add_random_mix(120);
        wait_idle();

        // threshold 1: fill both rings past full, then drain them
        write_reg(CFG_FLOW_THRESHOLD, 8'd1);
        write_reg(CFG_STOP_CODE, 8'd0);
        write_reg(CFG_RASTER_START, 8'd0);
        write_reg(CFG_RASTER_END, 8'hFF);
        for (k = 0; k < TX_SLOTS + 1; k++)
            push_event(KIND_TX_WRITE, 8'($urandom));
        for (k = 0; k < RX_SLOTS + 2; k++)
            push_event(KIND_LINE_RX, 8'($urandom_range(255, 32)));
        for (k = 0; k < TX_SLOTS + 4; k++)
            push_event(KIND_LINE_READY, 8'($urandom));
        for (k = 0; k < RX_SLOTS + 2; k++)
            push_event(KIND_PROTO_READ, 8'($urandom));
        push_event(KIND_LINE_READY, 8'h00);
        push_event(KIND_LINE_READY, 8'hFF);
        wait_idle();

        write_reg(CFG_FLOW_THRESHOLD, 8'($urandom_range(254, 240)));
        write_reg(CFG_STOP_CODE, 8'($urandom));
        write_reg(CFG_RESUME_CODE, 8'($urandom));
        write_reg(CFG_STATUS_CODE, 8'($urandom));
        write_reg(CFG_SUPER_CODE, 8'($urandom));
        write_reg(CFG_RASTER_START, 8'($urandom_range(255, 32)));
        write_reg(CFG_RASTER_END, 8'($urandom_range(255, 32)));
        add_random_mix(100);
        wait_idle();

        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
